// ===== hw/rtl/vfe_pkg.sv =====
// Package: types, constants, stage program and single-precision arithmetic functions.
package vfe_pkg;

    localparam int LANES      = 4;
    localparam int NUM_STAGES = 21;

    localparam logic [31:0] EXP_HI    = 32'h42B0C0A5;
    localparam logic [31:0] EXP_LO    = 32'hC2B0C0A5;
    localparam logic [31:0] LOG2E_F   = 32'h3FB8AA3B;
    localparam logic [31:0] HALF_F    = 32'h3F000000;
    localparam logic [31:0] ONE_F     = 32'h3F800000;
    localparam logic [31:0] RED_C1    = 32'h3F318000;
    localparam logic [31:0] RED_C2    = 32'hB95E8083;
    localparam logic [31:0] POLY_P0   = 32'h39506967;
    localparam logic [31:0] POLY_P1   = 32'h3AB743CE;
    localparam logic [31:0] POLY_P2   = 32'h3C088908;
    localparam logic [31:0] POLY_P3   = 32'h3D2AA9C1;
    localparam logic [31:0] POLY_P4   = 32'h3E2AAAAA;
    localparam logic [31:0] POLY_P5   = 32'h3F000000;
    localparam logic [31:0] QNAN_BITS = 32'h7FC00000;
    localparam logic [31:0] INF_MAG   = 32'h7F800000;
    localparam logic [31:0] EXP_BIAS  = 32'd127;
    localparam int          MANT_BITS = 23;

    typedef enum logic [4:0] {
        OP_CLAMP,
        OP_MUL_LOG2E,
        OP_ADD_HALF,
        OP_FLOOR,
        OP_RED_MUL,
        OP_RED_SUB1,
        OP_RED_SUB2,
        OP_POLY_INIT,
        OP_ADD_P1,
        OP_ADD_P2,
        OP_ADD_P3,
        OP_ADD_P4,
        OP_ADD_P5,
        OP_MUL_X,
        OP_MUL_Z,
        OP_ADD_X,
        OP_ADD_ONE,
        OP_SCALE
    } t_op;

    typedef struct packed {
        logic        nan;
        logic [8:0]  n;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
    } t_lane;

    typedef t_lane [LANES-1:0] t_vec;

    localparam t_op STAGE_OPS [NUM_STAGES] = '{
        OP_CLAMP, OP_MUL_LOG2E, OP_ADD_HALF, OP_FLOOR, OP_RED_MUL, OP_RED_SUB1,
        OP_RED_SUB2, OP_POLY_INIT, OP_ADD_P1, OP_MUL_X, OP_ADD_P2, OP_MUL_X,
        OP_ADD_P3, OP_MUL_X, OP_ADD_P4, OP_MUL_X, OP_ADD_P5, OP_MUL_Z,
        OP_ADD_X, OP_ADD_ONE, OP_SCALE
    };

    // The value is m / 2^49 * 2^(e - 127); m must be nonzero.
    function automatic logic [31:0] fp_round_pack(input logic s, input logic signed [11:0] e_in,
                                                  input logic [49:0] m_in);
        logic [49:0]        m;
        logic signed [11:0] e;
        logic [5:0]         lz;
        logic [5:0]         sh;
        logic               st;
        logic               rnd;
        logic [24:0]        r;
        logic [31:0]        res;
        m  = m_in;
        e  = e_in;
        lz = '0;
        for (int i = 0; i < 50; i++) begin
            if (m[i]) begin
                lz = 6'(49 - i);
            end
        end
        m = m << lz;
        e = e - $signed({6'd0, lz});
        if (e < 12'sd1) begin
            if (e < -12'sd48) begin
                m = {49'd0, |m};
            end else begin
                sh = 6'(12'sd1 - e);
                st = |(m & ((50'd1 << sh) - 50'd1));
                m  = (m >> sh) | {49'd0, st};
            end
            e = 12'sd1;
        end
        st  = |m[24:0];
        rnd = m[25] & (st | m[26]);
        r   = {1'b0, m[49:26]} + {24'd0, rnd};
        if (r[24]) begin
            r = r >> 1;
            e = e + 12'sd1;
        end
        if (e >= 12'sd255) begin
            res = {s, 8'hFF, 23'd0};
        end else begin
            res = {s, (r[23] ? e[7:0] : 8'd0), r[22:0]};
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_mul(input logic [31:0] a, input logic [31:0] b);
        logic        s;
        logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
        logic [7:0]  ea, eb;
        logic [23:0] ma, mb;
        logic [47:0] p;
        logic [31:0] res;
        s      = a[31] ^ b[31];
        a_nan  = a[30:0] > INF_MAG[30:0];
        b_nan  = b[30:0] > INF_MAG[30:0];
        a_inf  = a[30:0] == INF_MAG[30:0];
        b_inf  = b[30:0] == INF_MAG[30:0];
        a_zero = a[30:0] == 31'd0;
        b_zero = b[30:0] == 31'd0;
        ea     = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb     = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {a[30:23] != 8'd0, a[22:0]};
        mb     = {b[30:23] != 8'd0, b[22:0]};
        p      = 48'(ma) * 48'(mb);
        if (a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero)) begin
            res = QNAN_BITS;
        end else if (a_inf || b_inf) begin
            res = {s, 8'hFF, 23'd0};
        end else if (a_zero || b_zero) begin
            res = {s, 31'd0};
        end else begin
            res = fp_round_pack(s, $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126,
                                {p, 2'b00});
        end
        return res;
    endfunction

    function automatic logic [31:0] fp_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] big, lil;
        logic [7:0]  eg, el, d;
        logic [49:0] mx, my;
        logic [50:0] sum;
        logic [49:0] m;
        logic [11:0] e;
        logic        st;
        logic [31:0] res;
        if (b[30:0] > a[30:0]) begin
            big = b;
            lil = a;
        end else begin
            big = a;
            lil = b;
        end
        eg = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        el = (lil[30:23] == 8'd0) ? 8'd1 : lil[30:23];
        d  = eg - el;
        mx = {big[30:23] != 8'd0, big[22:0], 26'd0};
        my = {lil[30:23] != 8'd0, lil[22:0], 26'd0};
        if (d >= 8'd50) begin
            my = {49'd0, |my};
        end else begin
            st = |(my & ((50'd1 << d) - 50'd1));
            my = (my >> d) | {49'd0, st};
        end
        if (big[31] == lil[31]) begin
            sum = {1'b0, mx} + {1'b0, my};
        end else begin
            sum = {1'b0, mx} - {1'b0, my};
        end
        if (sum[50]) begin
            m = sum[50:1] | {49'd0, sum[0]};
            e = {4'd0, eg} + 12'd1;
        end else begin
            m = sum[49:0];
            e = {4'd0, eg};
        end
        if (a[30:0] > INF_MAG[30:0] || b[30:0] > INF_MAG[30:0]) begin
            res = QNAN_BITS;
        end else if (big[30:0] == INF_MAG[30:0]) begin
            if (lil[30:0] == INF_MAG[30:0] && lil[31] != big[31]) begin
                res = QNAN_BITS;
            end else begin
                res = big;
            end
        end else if (sum == 51'd0) begin
            res = {a[31] & b[31], 31'd0};
        end else begin
            res = fp_round_pack(big[31], $signed(e), m);
        end
        return res;
    endfunction

    // Floor of a value whose magnitude stays below 256, as a 9-bit two's complement integer.
    function automatic logic [8:0] fp_floor_int(input logic [31:0] f);
        logic [23:0] m;
        logic [2:0]  sh;
        logic [4:0]  rs;
        logic [8:0]  ip;
        logic        frac;
        logic [8:0]  res;
        m = {1'b1, f[22:0]};
        if (f[30:23] < 8'd127) begin
            ip   = 9'd0;
            frac = |f[30:0];
        end else begin
            sh   = (f[30:23] > 8'd134) ? 3'd7 : 3'(f[30:23] - 8'd127);
            rs   = 5'd23 - {2'b00, sh};
            ip   = 9'(m >> rs);
            frac = |(m & ((24'd1 << rs) - 24'd1));
        end
        if (f[31]) begin
            res = 9'd0 - ip - {8'd0, frac};
        end else begin
            res = ip;
        end
        return res;
    endfunction

    function automatic logic [31:0] int_to_fp(input logic [8:0] n);
        logic [8:0]  mag;
        logic [3:0]  p;
        logic [31:0] sh;
        logic [31:0] res;
        mag = n[8] ? 9'(9'd0 - n) : n;
        p   = '0;
        for (int i = 0; i < 9; i++) begin
            if (mag[i]) begin
                p = 4'(i);
            end
        end
        sh = {23'd0, mag} << (5'd23 - {1'b0, p});
        if (mag == 9'd0) begin
            res = 32'd0;
        end else begin
            res = {n[8], 8'(8'd127 + {4'd0, p}), sh[22:0]};
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/vfe_stage.sv =====
// One pipeline stage: the operation selected by i_op on every lane, with its own output register.
module vfe_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  vfe_pkg::t_op  i_op,
    input  logic          i_valid,
    output logic          o_ready,
    input  vfe_pkg::t_vec i_data,
    output logic          o_valid,
    input  logic          i_ready,
    output vfe_pkg::t_vec o_data
);
    import vfe_pkg::*;

    logic r_valid;
    t_vec r_data;
    t_vec n_data;

    assign o_ready = !r_valid || i_ready;
    assign o_valid = r_valid;
    assign o_data  = r_data;

    always_comb begin
        logic [8:0]  fl;
        logic [31:0] sc;
        n_data = i_data;
        for (int l = 0; l < LANES; l++) begin
            fl = fp_floor_int(i_data[l].y);
            sc = ({{23{i_data[l].n[8]}}, i_data[l].n} + EXP_BIAS) << MANT_BITS;
            unique case (i_op)
                OP_CLAMP: begin
                    n_data[l].nan = i_data[l].x[30:0] > INF_MAG[30:0];
                    if (!i_data[l].x[31] && i_data[l].x[30:0] > EXP_HI[30:0]) begin
                        n_data[l].x = EXP_HI;
                    end else if (i_data[l].x[31] && i_data[l].x[30:0] > EXP_LO[30:0]) begin
                        n_data[l].x = EXP_LO;
                    end
                end
                OP_MUL_LOG2E: n_data[l].y = fp_mul(i_data[l].x, LOG2E_F);
                OP_ADD_HALF:  n_data[l].y = fp_add(i_data[l].y, HALF_F);
                OP_FLOOR: begin
                    n_data[l].n = fl;
                    n_data[l].y = int_to_fp(fl);
                end
                OP_RED_MUL: begin
                    n_data[l].z = fp_mul(i_data[l].y, RED_C1);
                    n_data[l].y = fp_mul(i_data[l].y, RED_C2);
                end
                OP_RED_SUB1: n_data[l].x = fp_add(i_data[l].x, {~i_data[l].z[31], i_data[l].z[30:0]});
                OP_RED_SUB2: n_data[l].x = fp_add(i_data[l].x, {~i_data[l].y[31], i_data[l].y[30:0]});
                OP_POLY_INIT: begin
                    n_data[l].y = fp_mul(POLY_P0, i_data[l].x);
                    n_data[l].z = fp_mul(i_data[l].x, i_data[l].x);
                end
                OP_ADD_P1:  n_data[l].y = fp_add(i_data[l].y, POLY_P1);
                OP_ADD_P2:  n_data[l].y = fp_add(i_data[l].y, POLY_P2);
                OP_ADD_P3:  n_data[l].y = fp_add(i_data[l].y, POLY_P3);
                OP_ADD_P4:  n_data[l].y = fp_add(i_data[l].y, POLY_P4);
                OP_ADD_P5:  n_data[l].y = fp_add(i_data[l].y, POLY_P5);
                OP_MUL_X:   n_data[l].y = fp_mul(i_data[l].y, i_data[l].x);
                OP_MUL_Z:   n_data[l].y = fp_mul(i_data[l].y, i_data[l].z);
                OP_ADD_X:   n_data[l].y = fp_add(i_data[l].y, i_data[l].x);
                OP_ADD_ONE: n_data[l].y = fp_add(i_data[l].y, ONE_F);
                OP_SCALE: begin
                    n_data[l].y = i_data[l].nan ? QNAN_BITS : fp_mul(i_data[l].y, sc);
                end
                default: n_data[l] = i_data[l];
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_ready && i_valid) begin
            r_data <= n_data;
        end
    end

endmodule

// ===== hw/rtl/vector_float_exp_core.sv =====
// Top level: four-lane single-precision exp pipeline with valid/ready channels.
//
// Each transaction on the input channel carries four binary32 bit patterns, one per lane,
// and each transaction on the output channel carries exp of those four values.
// Results leave in the order their inputs arrived, exactly one per input transaction.
// The datapath is 21 register stages, one rounded add or one or two rounded multiplies
// (or the clamp and floor steps) per stage; each transaction passes through all of them.
// A new transaction can be accepted every cycle while i_ready stays high, one vector per cycle sustained.
// Every stage holds its own valid bit, and a stage takes new data when it is empty or
// when the stage after it is moving, so bubbles close up as the pipeline drains.
// When the receiver holds i_ready low the last stage keeps its result; the stages
// before it keep filling until all 21 are full, and only then is o_ready pulled low.
// A NaN input lane gives the quiet NaN 0x7FC00000 in that lane of the result.
// Synchronous reset clears all valid bits; no clearing pass or setup is needed after it.
module vector_float_exp_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_lane0_in,
    input  logic [31:0] i_lane1_in,
    input  logic [31:0] i_lane2_in,
    input  logic [31:0] i_lane3_in,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_lane0_out,
    output logic [31:0] o_lane1_out,
    output logic [31:0] o_lane2_out,
    output logic [31:0] o_lane3_out
);
    import vfe_pkg::*;

    logic stg_valid [NUM_STAGES+1];
    logic stg_ready [NUM_STAGES+1];
    t_vec stg_data  [NUM_STAGES+1];

    always_comb begin
        stg_data[0] = '0;
        stg_data[0][0].x = i_lane0_in;
        stg_data[0][1].x = i_lane1_in;
        stg_data[0][2].x = i_lane2_in;
        stg_data[0][3].x = i_lane3_in;
    end

    assign stg_valid[0]          = i_valid;
    assign o_ready               = stg_ready[0];
    assign stg_ready[NUM_STAGES] = i_ready;
    assign o_valid               = stg_valid[NUM_STAGES];
    assign o_lane0_out           = stg_data[NUM_STAGES][0].y;
    assign o_lane1_out           = stg_data[NUM_STAGES][1].y;
    assign o_lane2_out           = stg_data[NUM_STAGES][2].y;
    assign o_lane3_out           = stg_data[NUM_STAGES][3].y;

    for (genvar k = 0; k < NUM_STAGES; k++) begin : g_stage
        vfe_stage u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_op    (STAGE_OPS[k]),
            .i_valid (stg_valid[k]),
            .o_ready (stg_ready[k]),
            .i_data  (stg_data[k]),
            .o_valid (stg_valid[k+1]),
            .i_ready (stg_ready[k+1]),
            .o_data  (stg_data[k+1])
        );
    end

endmodule

// ===== test/tb_vector_float_exp_core.sv =====
// Testbench for vector_float_exp_core: directed and random vectors checked against a float predictor or typed results.
module tb_vector_float_exp_core;
    timeunit 1ns;
    timeprecision 1ps;
    import vfe_pkg::*;

    typedef logic [LANES-1:0][31:0] t_lanes;

    typedef struct {
        t_lanes arg;
        bit     typed;
        t_lanes res;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_ready;
    logic [31:0] i_lane0_in = '0;
    logic [31:0] i_lane1_in = '0;
    logic [31:0] i_lane2_in = '0;
    logic [31:0] i_lane3_in = '0;
    logic        o_valid;
    logic        i_ready = 1'b0;
    logic [31:0] o_lane0_out;
    logic [31:0] o_lane1_out;
    logic [31:0] o_lane2_out;
    logic [31:0] o_lane3_out;

    t_lanes exp_queue[$];
    int     mismatches = 0;
    bit     idling_on = 1'b1;
    bit     long_hold = 1'b0;

    vector_float_exp_core dut (.*);

    always #5 i_clk = ~i_clk;

    function automatic logic [31:0] round_to_f32(real v);
        logic [63:0] d, m, q, rem, half;
        logic        s;
        int          e, sh;
        d = $realtobits(v);
        s = d[63];
        if (d[62:52] == 11'h7FF) begin
            return (d[51:0] != 0) ? QNAN_BITS : {s, 8'hFF, 23'd0};
        end
        if (d[62:0] == 63'd0) begin
            return {s, 31'd0};
        end
        e  = int'(d[62:52]) - 1023 + 127;
        m  = {11'd0, 1'b1, d[51:0]};
        sh = (e >= 1) ? 29 : 30 - e;
        if (sh > 60) begin
            return {s, 31'd0};
        end
        q    = m >> sh;
        rem  = m & ((64'd1 << sh) - 64'd1);
        half = 64'd1 << (sh - 1);
        if (rem > half || (rem == half && q[0])) begin
            q = q + 64'd1;
        end
        if (e >= 1) begin
            if (q[24]) begin
                q = q >> 1;
                e = e + 1;
            end
            if (e >= 255) begin
                return {s, 8'hFF, 23'd0};
            end
            return {s, 8'(e), q[22:0]};
        end
        return {s, q[30:0]};
    endfunction

    function automatic real f32_value(logic [31:0] f);
        real r;
        if (f[30:23] == 8'hFF) begin
            return (f[22:0] != 0) ? $bitstoreal(64'h7FF8000000000000)
                                  : $bitstoreal({f[31], 11'h7FF, 52'd0});
        end
        if (f[30:23] == 8'd0) begin
            r = real'(f[22:0]) * 2.0 ** (-149);
            return f[31] ? -r : r;
        end
        return $bitstoreal({f[31], 11'(int'(f[30:23]) - 127 + 1023), f[22:0], 29'd0});
    endfunction

    function automatic real rnd32(real v);
        return f32_value(round_to_f32(v));
    endfunction

    function automatic logic [31:0] exp_of_lane(logic [31:0] arg);
        real         x, fx, t, tmp, z, y;
        int          n;
        logic [31:0] scale;
        if (arg[30:0] > INF_MAG[30:0]) begin
            return QNAN_BITS;
        end
        x = f32_value(arg);
        if (x > f32_value(EXP_HI)) begin
            x = f32_value(EXP_HI);
        end
        if (x < f32_value(EXP_LO)) begin
            x = f32_value(EXP_LO);
        end
        t   = rnd32(x * f32_value(LOG2E_F));
        fx  = rnd32(t + 0.5);
        n   = $rtoi(fx);
        tmp = real'(n);
        if (tmp > fx) begin
            tmp = rnd32(tmp - 1.0);
        end
        fx = tmp;
        t  = rnd32(fx * f32_value(RED_C1));
        z  = rnd32(fx * f32_value(RED_C2));
        x  = rnd32(x - t);
        x  = rnd32(x - z);
        y  = rnd32(f32_value(POLY_P0) * x);
        z  = rnd32(x * x);
        y  = rnd32(y + f32_value(POLY_P1));
        y  = rnd32(y * x);
        y  = rnd32(y + f32_value(POLY_P2));
        y  = rnd32(y * x);
        y  = rnd32(y + f32_value(POLY_P3));
        y  = rnd32(y * x);
        y  = rnd32(y + f32_value(POLY_P4));
        y  = rnd32(y * x);
        y  = rnd32(y + f32_value(POLY_P5));
        y  = rnd32(y * z);
        y  = rnd32(y + x);
        y  = rnd32(y + 1.0);
        n     = $rtoi(fx);
        scale = (32'(n) + EXP_BIAS) << MANT_BITS;
        return round_to_f32(y * f32_value(scale));
    endfunction

    function automatic logic [31:0] random_arg();
        if ($urandom_range(0, 3) == 0) begin
            return $urandom;
        end
        return {1'($urandom), 8'($urandom_range(100, 134)), 23'($urandom)};
    endfunction

    task automatic send_vector(t_lanes arg, bit typed, t_lanes typed_res);
        t_lanes want;
        i_valid    <= 1'b1;
        i_lane0_in <= arg[0];
        i_lane1_in <= arg[1];
        i_lane2_in <= arg[2];
        i_lane3_in <= arg[3];
        do @(posedge i_clk); while (!o_ready);
        for (int l = 0; l < LANES; l++) begin
            want[l] = exp_of_lane(arg[l]);
        end
        exp_queue.push_back(typed ? typed_res : want);
        if (idling_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin
        t_lanes got, want;
        if (i_rst_n && o_valid && i_ready) begin
            got = {o_lane3_out, o_lane2_out, o_lane1_out, o_lane0_out};
            if (exp_queue.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("Unexpected transaction: %h", got);
                end
            end else begin
                want = exp_queue.pop_front();
                for (int l = 0; l < LANES; l++) begin
                    if (got[l] !== want[l]) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("Lane %0d mismatch: expected %h, actual %h",
                                     l, want[l], got[l]);
                        end
                    end
                end
            end
        end
    end

    initial begin
        forever begin
            if (long_hold) begin
                i_ready <= 1'b0;
                repeat (60) @(posedge i_clk);
                long_hold = 1'b0;
            end else if (idling_on && $urandom_range(0, 3) == 0) begin
                i_ready <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge i_clk);
            end
            i_ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    initial begin
        #2ms;
        $display("FAILED: results differ");
        $finish;
    end

    initial begin
        t_row   rows[$];
        t_row   row;
        t_lanes arg;
        t_lanes none;
        none = '0;
        rows.push_back('{'{32'h00000000, 32'h80000000, 32'h00000000, 32'h80000000}, 1'b1,
                         '{ONE_F, ONE_F, ONE_F, ONE_F}});
        rows.push_back('{'{32'h7FC00000, 32'hFFC00000, 32'h7F800001, 32'hFFFFFFFF}, 1'b1,
                         '{QNAN_BITS, QNAN_BITS, QNAN_BITS, QNAN_BITS}});
        rows.push_back('{'{32'h7F800000, 32'hFF800000, 32'h7F7FFFFF, 32'hFF7FFFFF}, 1'b0, none});
        rows.push_back('{'{32'h00000001, 32'h80000001, 32'h007FFFFF, 32'h807FFFFF}, 1'b0, none});
        rows.push_back('{'{EXP_HI, EXP_LO, 32'h42B0C0A4, 32'hC2B0C0A4}, 1'b0, none});
        rows.push_back('{'{32'h42B17218, 32'hC2B17218, 32'h42C80000, 32'hC2C80000}, 1'b0, none});
        rows.push_back('{'{ONE_F, 32'hBF800000, 32'h3F317218, 32'hBF317218}, 1'b0, none});
        rows.push_back('{'{32'h3EB17218, 32'hBEB17218, 32'h3EB17217, 32'hBEB17219}, 1'b0, none});
        rows.push_back('{'{32'h42AE0000, 32'hC2AE0000, 32'h41200000, 32'hC1200000}, 1'b0, none});
        rows.push_back('{'{32'h33800000, 32'hB3800000, 32'h00800000, 32'h80800000}, 1'b0, none});
        rows.push_back('{'{32'hFFFFFFFF, 32'h55555555, 32'hAAAAAAAA, 32'h7FFFFFFE}, 1'b0, none});

        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (rows[i]) begin
            row = rows[i];
            send_vector(row.arg, row.typed, row.res);
        end
        for (int k = 0; k < 1040; k++) begin
            if (k == 300) begin
                long_hold = 1'b1;
            end
            if (k == 600) begin
                i_valid <= 1'b0;
                wait (exp_queue.size() == 0);
                @(posedge i_clk);
            end
            if (k == 940) begin
                idling_on = 1'b0;
            end
            for (int l = 0; l < LANES; l++) begin
                arg[l] = random_arg();
            end
            send_vector(arg, 1'b0, none);
        end
        i_valid <= 1'b0;
        wait (exp_queue.size() == 0);
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && exp_queue.size() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end
endmodule

// ===== vector_float_exp_core.f =====
hw/rtl/vfe_pkg.sv
hw/rtl/vfe_stage.sv
hw/rtl/vector_float_exp_core.sv
test/tb_vector_float_exp_core.sv
